// ----- rtl/tfn_pkg.sv -----
// ----------------------------------------------------------------------------
// tfn_pkg: shared constants for the triangle face normal block
// Default widths and the fixed ranges used by the normalization datapath.
// ----------------------------------------------------------------------------
package tfn_pkg;

	// default field widths
	localparam int COORD_BITS_DEF       = 16;
	localparam int NORMAL_FRAC_BITS_DEF = 14;

	// edge magnitudes are brought below 2^EDGE_LIMIT_BIT before the cross product
	localparam int EDGE_LIMIT_BIT = 31;

	// cross magnitudes are brought below 2^NRM_MAG_BITS before squaring
	localparam int NRM_MAG_BITS = 30;

	// sum of three squares of NRM_MAG_BITS values, and its square root
	localparam int SUM_BITS  = 2 * NRM_MAG_BITS + 2;
	localparam int ROOT_BITS = NRM_MAG_BITS + 1;

endpackage

// ----- rtl/tfn_vtx_if.sv -----
// ----------------------------------------------------------------------------
// tfn_vtx_if: vertex channel
// Valid/ready channel carrying one vertex word per handshake.
// ----------------------------------------------------------------------------
interface tfn_vtx_if
	import tfn_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] x_coord;
	logic signed [COORD_BITS-1:0] y_coord;
	logic signed [COORD_BITS-1:0] z_coord;
	logic                         start_of_mesh;

	modport source (
		output valid, x_coord, y_coord, z_coord, start_of_mesh,
		input  ready
	);

	modport sink (
		input  valid, x_coord, y_coord, z_coord, start_of_mesh,
		output ready
	);
endinterface

// ----- rtl/tfn_nrm_if.sv -----
// ----------------------------------------------------------------------------
// tfn_nrm_if: face normal channel
// Valid/ready channel carrying one unit normal word per handshake.
// ----------------------------------------------------------------------------
interface tfn_nrm_if
	import tfn_pkg::*;
#(
	parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) ();
	localparam int NB = NORMAL_FRAC_BITS + 2;

	logic                 valid;
	logic                 ready;
	logic signed [NB-1:0] normal_x;
	logic signed [NB-1:0] normal_y;
	logic signed [NB-1:0] normal_z;
	logic                 degenerate;

	modport source (
		output valid, normal_x, normal_y, normal_z, degenerate,
		input  ready
	);

	modport sink (
		input  valid, normal_x, normal_y, normal_z, degenerate,
		output ready
	);
endinterface

// ----- rtl/tfn_rootdiv.sv -----
// ----------------------------------------------------------------------------
// tfn_rootdiv: iterative square root and three rounded divisions
// One shared subtract/compare unit: first the integer square root of the
// sum of squares (one result bit per cycle), then each cross magnitude is
// divided by that length (one quotient bit per cycle) and rounded.
// ----------------------------------------------------------------------------
module tfn_rootdiv
	import tfn_pkg::*;
#(
	parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [SUM_BITS-1:0]         sum,
	input  logic [NRM_MAG_BITS-1:0]     nm   [3],
	output logic                        done,
	output logic [NORMAL_FRAC_BITS:0]   mag  [3]
);
	localparam int QW = NORMAL_FRAC_BITS + 2;
	localparam int CW = $clog2(QW);

	localparam logic [1:0] RD_IDLE = 2'd0;
	localparam logic [1:0] RD_ROOT = 2'd1;
	localparam logic [1:0] RD_DIV  = 2'd2;
	localparam logic [1:0] RD_DONE = 2'd3;

	logic [1:0]           state_q;
	logic [SUM_BITS-1:0]  rem_q;
	logic [SUM_BITS-1:0]  root_q;
	logic [SUM_BITS-1:0]  bit_q;
	logic [ROOT_BITS-1:0] len_q;
	logic                 nxt_q;
	logic [QW-1:0]        quo_q;
	logic [CW-1:0]        cnt_q;
	logic [1:0]           idx_q;

	logic [SUM_BITS-1:0]  sub_a;
	logic [SUM_BITS-1:0]  sub_b;
	logic [SUM_BITS:0]    sub_d;
	logic                 ge;
	logic [SUM_BITS-1:0]  root_nxt;
	logic [QW-1:0]        quo_nxt;
	logic [QW:0]          quo_rnd;

	// shared subtract/compare unit
	always_comb begin
		sub_a = rem_q;
		sub_b = root_q + bit_q;
		if (state_q == RD_DIV) begin
			sub_a = SUM_BITS'({rem_q[ROOT_BITS-1:0], nxt_q});
			sub_b = SUM_BITS'(len_q);
		end
	end

	assign sub_d    = {1'b0, sub_a} - {1'b0, sub_b};
	assign ge       = ~sub_d[SUM_BITS];
	assign root_nxt = ge ? ((root_q >> 1) + bit_q) : (root_q >> 1);
	assign quo_nxt  = {quo_q[QW-2:0], ge};
	assign quo_rnd  = {1'b0, quo_nxt} + (QW+1)'(1);
	assign done     = (state_q == RD_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RD_IDLE;
		end else begin
			unique case (state_q)
				RD_IDLE: begin
					if (start) begin
						rem_q   <= sum;
						root_q  <= '0;
						bit_q   <= SUM_BITS'(1) << (SUM_BITS - 2);
						state_q <= RD_ROOT;
					end
				end
				RD_ROOT: begin
					if (ge) begin
						rem_q <= sub_d[SUM_BITS-1:0];
					end
					root_q <= root_nxt;
					bit_q  <= bit_q >> 2;
					if (bit_q[0]) begin
						// root settled: load the first dividend
						len_q   <= root_nxt[ROOT_BITS-1:0];
						rem_q   <= SUM_BITS'(nm[0] >> 1);
						nxt_q   <= nm[0][0];
						cnt_q   <= '0;
						idx_q   <= 2'd0;
						state_q <= RD_DIV;
					end
				end
				RD_DIV: begin
					rem_q <= ge ? sub_d[SUM_BITS-1:0] : sub_a;
					nxt_q <= 1'b0;
					quo_q <= quo_nxt;
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(QW - 1)) begin
						mag[idx_q] <= quo_rnd[QW-1:1];
						cnt_q      <= '0;
						if (idx_q == 2'd2) begin
							state_q <= RD_DONE;
						end else begin
							rem_q <= SUM_BITS'(nm[idx_q + 2'd1] >> 1);
							nxt_q <= nm[idx_q + 2'd1][0];
							idx_q <= idx_q + 2'd1;
						end
					end
				end
				default: begin
					state_q <= RD_IDLE;
				end
			endcase
		end
	end
endmodule

// ----- rtl/triangle_face_normal.sv -----
// ----------------------------------------------------------------------------
// triangle_face_normal: flat face normal of a vertex stream
// Groups vertices three at a time and emits one unit normal per triangle.
// ----------------------------------------------------------------------------
// Vertices arrive one word at a time on the vertex channel and are grouped
// into triangles a, b, c; start_of_mesh makes the current vertex corner a.
// The first two corners of a group are only held. The third corner starts
// the face computation and the block stays not ready until that face is
// done: edge ranging, six cross-product terms through one registered
// multiplier, a zero test, one-bit-per-cycle range shifts of the cross
// vector, three squares on the same multiplier, a bit-serial square root
// and three bit-serial divisions of NORMAL_FRAC_BITS+2 quotient bits each,
// the hand-back of the result, then the load of the output register. The
// root and divisions run on the shared subtract/compare unit in tfn_rootdiv.
// A degenerate face skips the range shifts, squares, root and divisions.
// The output register holds a finished word while new vertices are taken;
// a pending face only waits in its last state if the previous word has not
// been taken yet.
module triangle_face_normal
	import tfn_pkg::*;
#(
	parameter int COORD_BITS       = COORD_BITS_DEF,
	parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	tfn_vtx_if.sink   vertex,
	tfn_nrm_if.source normal
);
	// magnitude width of the edges after ranging
	localparam int MW  = (COORD_BITS > EDGE_LIMIT_BIT) ? EDGE_LIMIT_BIT : COORD_BITS;
	// multiplier operand width: edges with sign, or cross magnitudes to be squared
	localparam int OPW = (MW + 1 > NRM_MAG_BITS + 1) ? MW + 1 : NRM_MAG_BITS + 1;
	localparam int PW  = 2 * OPW;
	// cross product magnitude width
	localparam int NMW = 2 * MW + 1;
	localparam int NB  = NORMAL_FRAC_BITS + 2;

	localparam logic [2:0] MUL_STEPS = 3'd6;
	localparam logic [2:0] SQ_STEPS  = 3'd3;

	// sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_ESHIFT = 3'd1;
	localparam logic [2:0] S_MUL    = 3'd2;
	localparam logic [2:0] S_CHECK  = 3'd3;
	localparam logic [2:0] S_NSHIFT = 3'd4;
	localparam logic [2:0] S_SQ     = 3'd5;
	localparam logic [2:0] S_ROOT   = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	logic [2:0]            state_q;
	logic [1:0]            phase_q;
	logic [2:0]            cnt_q;

	// held corners
	logic [COORD_BITS-1:0] first_q  [3];
	logic [COORD_BITS-1:0] second_q [3];

	// edges e (0..2) and f (3..5) as sign and magnitude
	logic                  esign_q  [6];
	logic [COORD_BITS-1:0] emag_q   [6];

	// multiplier pipeline and cross product
	logic signed [PW-1:0]  prod_q;
	logic signed [PW-1:0]  acc_q;
	logic                  nsign_q  [3];
	logic [NMW-1:0]        nmag_q   [3];
	logic [SUM_BITS-1:0]   sum_q;
	logic                  degen_q;
	logic                  rd_start_q;

	// output register
	logic                  out_valid_q;
	logic [NB-1:0]         nx_q;
	logic [NB-1:0]         ny_q;
	logic [NB-1:0]         nz_q;
	logic                  odegen_q;

	logic [COORD_BITS-1:0]   cin     [3];
	logic signed [COORD_BITS:0] ediff [6];
	logic [COORD_BITS-1:0]   emag_d  [6];
	logic [COORD_BITS-1:0]   emag_or;
	logic                    edge_big;
	logic [NMW-1:0]          nm_or;
	logic                    nm_big;
	logic signed [OPW-1:0]   eop     [6];
	logic signed [OPW-1:0]   op_a;
	logic signed [OPW-1:0]   op_b;
	logic signed [PW-1:0]    prod_d;
	logic signed [PW-1:0]    ndiff;
	logic [2:0]              ai;
	logic [2:0]              bi;
	logic [2:0]              mstep;
	logic [1:0]              ni;
	logic [1:0]              phase_eff;
	logic                    in_acc;
	logic                    out_free;
	logic [NRM_MAG_BITS-1:0] nm_rd   [3];
	logic                    rd_done;
	logic [NORMAL_FRAC_BITS:0] rd_mag [3];

	function automatic logic [NB-1:0] to_field(input logic neg,
			input logic [NORMAL_FRAC_BITS:0] m);
		logic [NB-1:0] v;
		v = NB'(m);
		return neg ? (~v + NB'(1)) : v;
	endfunction

	assign cin[0] = vertex.x_coord;
	assign cin[1] = vertex.y_coord;
	assign cin[2] = vertex.z_coord;

	assign vertex.ready = (state_q == S_IDLE);
	assign in_acc       = vertex.valid && vertex.ready;
	assign phase_eff    = vertex.start_of_mesh ? 2'd0 : phase_q;
	assign out_free     = !out_valid_q || normal.ready;

	// edges against corner a, one bit wider than the coordinates
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ediff[i]     = $signed({second_q[i][COORD_BITS-1], second_q[i]})
				- $signed({first_q[i][COORD_BITS-1], first_q[i]});
			ediff[i + 3] = $signed({cin[i][COORD_BITS-1], cin[i]})
				- $signed({first_q[i][COORD_BITS-1], first_q[i]});
		end
		for (int i = 0; i < 6; i++) begin
			emag_d[i] = COORD_BITS'(ediff[i][COORD_BITS] ? -ediff[i] : ediff[i]);
		end
	end

	// range tests for edge and cross magnitudes
	always_comb begin
		emag_or = '0;
		for (int i = 0; i < 6; i++) begin
			emag_or = emag_or | emag_q[i];
		end
		nm_or = nmag_q[0] | nmag_q[1] | nmag_q[2];
	end

	assign edge_big = (emag_or >> EDGE_LIMIT_BIT) != '0;
	assign nm_big   = (nm_or >> NRM_MAG_BITS) != '0;

	// signed edge operands
	always_comb begin
		for (int i = 0; i < 6; i++) begin
			eop[i] = esign_q[i] ? -$signed(OPW'(emag_q[i])) : $signed(OPW'(emag_q[i]));
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		ai   = 3'd0;
		bi   = 3'd0;
		op_a = '0;
		op_b = '0;
		unique case (cnt_q)
			3'd0:    begin ai = 3'd1; bi = 3'd5; end
			3'd1:    begin ai = 3'd2; bi = 3'd4; end
			3'd2:    begin ai = 3'd2; bi = 3'd3; end
			3'd3:    begin ai = 3'd0; bi = 3'd5; end
			3'd4:    begin ai = 3'd0; bi = 3'd4; end
			3'd5:    begin ai = 3'd1; bi = 3'd3; end
			default: begin ai = 3'd0; bi = 3'd0; end
		endcase
		if (state_q == S_MUL) begin
			op_a = eop[ai];
			op_b = eop[bi];
		end else if (state_q == S_SQ && cnt_q < SQ_STEPS) begin
			op_a = $signed(OPW'(nmag_q[cnt_q[1:0]]));
			op_b = op_a;
		end
	end

	assign prod_d = op_a * op_b;
	assign ndiff  = acc_q - prod_q;
	assign mstep  = cnt_q - 3'd1;
	assign ni     = mstep[2:1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nm_rd[i] = NRM_MAG_BITS'(nmag_q[i]);
		end
	end

	tfn_rootdiv #(
		.NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
	) u_rootdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rd_start_q),
		.sum    (sum_q),
		.nm     (nm_rd),
		.done   (rd_done),
		.mag    (rd_mag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= 2'd0;
			cnt_q       <= 3'd0;
			rd_start_q  <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				first_q[i]  <= '0;
				second_q[i] <= '0;
			end
		end else begin
			rd_start_q <= 1'b0;
			if (out_valid_q && normal.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						unique case (phase_eff)
							2'd0: begin
								for (int i = 0; i < 3; i++) first_q[i] <= cin[i];
								phase_q <= 2'd1;
							end
							2'd1: begin
								for (int i = 0; i < 3; i++) second_q[i] <= cin[i];
								phase_q <= 2'd2;
							end
							default: begin
								// third corner: latch edges, start the face
								for (int i = 0; i < 6; i++) begin
									esign_q[i] <= ediff[i][COORD_BITS];
									emag_q[i]  <= emag_d[i];
								end
								phase_q <= 2'd0;
								state_q <= S_ESHIFT;
							end
						endcase
					end
				end
				S_ESHIFT: begin
					// bring all edge magnitudes into multiplier range together
					if (edge_big) begin
						for (int i = 0; i < 6; i++) emag_q[i] <= emag_q[i] >> 1;
					end else begin
						cnt_q   <= 3'd0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					// issue one product a cycle, fold the previous one
					if (cnt_q < MUL_STEPS) begin
						prod_q <= prod_d;
					end
					if (cnt_q != 3'd0) begin
						if (!mstep[0]) begin
							acc_q <= prod_q;
						end else begin
							nsign_q[ni] <= ndiff[PW-1];
							nmag_q[ni]  <= NMW'(ndiff[PW-1] ? -ndiff : ndiff);
						end
					end
					if (cnt_q == MUL_STEPS) begin
						state_q <= S_CHECK;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				S_CHECK: begin
					degen_q <= (nm_or == '0);
					state_q <= (nm_or == '0) ? S_DONE : S_NSHIFT;
				end
				S_NSHIFT: begin
					// common right shift until every component fits the squarer
					if (nm_big) begin
						for (int i = 0; i < 3; i++) nmag_q[i] <= nmag_q[i] >> 1;
					end else begin
						cnt_q   <= 3'd0;
						sum_q   <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					if (cnt_q < SQ_STEPS) begin
						prod_q <= prod_d;
					end
					if (cnt_q != 3'd0) begin
						sum_q <= sum_q + prod_q[SUM_BITS-1:0];
					end
					if (cnt_q == SQ_STEPS) begin
						rd_start_q <= 1'b1;
						state_q    <= S_ROOT;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				S_ROOT: begin
					if (rd_done) begin
						state_q <= S_DONE;
					end
				end
				default: begin
					// hold the face until the output register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						odegen_q    <= degen_q;
						if (degen_q) begin
							nx_q <= '0;
							ny_q <= '0;
							nz_q <= '0;
						end else begin
							nx_q <= to_field(nsign_q[0], rd_mag[0]);
							ny_q <= to_field(nsign_q[1], rd_mag[1]);
							nz_q <= to_field(nsign_q[2], rd_mag[2]);
						end
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign normal.valid      = out_valid_q;
	assign normal.normal_x   = nx_q;
	assign normal.normal_y   = ny_q;
	assign normal.normal_z   = nz_q;
	assign normal.degenerate = odegen_q;
endmodule

// ----- rtl/tfn_checker.sv -----
// ----------------------------------------------------------------------------
// tfn_checker: port-level checks for triangle_face_normal
// Watches the normal channel and checks word holding and normal sanity.
// ----------------------------------------------------------------------------
module tfn_checker #(
	parameter int NB = 16
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic signed [NB-1:0] nx,
	input logic signed [NB-1:0] ny,
	input logic signed [NB-1:0] nz,
	input logic                 degenerate
);
	localparam logic signed [NB-1:0] LIM = NB'(1) <<< (NB - 2);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("normal word dropped before it was taken");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({nx, ny, nz, degenerate}))
		else $error("normal word changed while stalled");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> nx == '0 && ny == '0 && nz == '0)
		else $error("degenerate face with nonzero normal");

	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !degenerate |-> nx != '0 || ny != '0 || nz != '0)
		else $error("non-degenerate face with zero normal");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> nx <= LIM && nx >= -LIM && ny <= LIM && ny >= -LIM
			&& nz <= LIM && nz >= -LIM)
		else $error("normal component beyond unit range");
endmodule

bind triangle_face_normal tfn_checker #(
	.NB (NORMAL_FRAC_BITS + 2)
) u_tfn_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (normal.valid),
	.out_ready  (normal.ready),
	.nx         (normal.normal_x),
	.ny         (normal.normal_y),
	.nz         (normal.normal_z),
	.degenerate (normal.degenerate)
);

// ----- test/tfn_face_checker.sv -----
// ----------------------------------------------------------------------------
// tfn_face_checker: face normal scoreboard
// Tracks the vertex grouping seen on the vertex channel and predicts one unit
// normal word per finished triangle. It compares each normal word taken from
// the block against the oldest prediction and counts mismatches.
// ----------------------------------------------------------------------------
module tfn_face_checker
	import tfn_pkg::*;
#(
	parameter int COORD_BITS       = COORD_BITS_DEF,
	parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	tfn_vtx_if   vertex,
	tfn_nrm_if   normal,
	output int   mismatches,
	output int   faces_due
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NB = NORMAL_FRAC_BITS + 2;

	localparam logic [1:0] CORNER_A = 2'd0;
	localparam logic [1:0] CORNER_B = 2'd1;

	typedef struct packed {
		logic signed [NB-1:0] nx;
		logic signed [NB-1:0] ny;
		logic signed [NB-1:0] nz;
		logic                 degenerate;
	} face_normal_t;

	face_normal_t normals_due[$];
	face_normal_t want;
	longint       corner_a [3];
	longint       corner_b [3];
	longint       corner_c [3];
	logic [1:0]   corner_phase;
	logic [1:0]   phase_now;

	function automatic longint unsigned magnitude(input longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	function automatic int bit_length(input longint unsigned v);
		int n;
		n = 0;
		while (v != 0) begin
			n++;
			v >>= 1;
		end
		return n;
	endfunction

	function automatic longint unsigned floor_sqrt(input longint unsigned s);
		longint unsigned root;
		longint unsigned probe;
		root  = 0;
		probe = 64'd1 << 62;
		while (probe > s)
			probe >>= 2;
		while (probe != 0) begin
			if (s >= root + probe) begin
				s    = s - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe >>= 2;
		end
		return root;
	endfunction

	function automatic face_normal_t face_normal(input longint a [3], input longint b [3],
			input longint c [3]);
		longint               e [3];
		longint               f [3];
		longint               n [3];
		longint unsigned      em [6];
		longint unsigned      nm [3];
		longint unsigned      peak;
		longint unsigned      sum;
		longint unsigned      len;
		longint unsigned      q;
		int                   k;
		logic signed [NB-1:0] comp [3];
		face_normal_t         r;

		peak = 0;
		for (int i = 0; i < 3; i++) begin
			e[i]     = b[i] - a[i];
			f[i]     = c[i] - a[i];
			em[i]    = magnitude(e[i]);
			em[i+3]  = magnitude(f[i]);
		end
		for (int i = 0; i < 6; i++)
			if (em[i] > peak) peak = em[i];

		// range the edges only when they are too wide for the cross product
		k = bit_length(peak);
		k = (k > EDGE_LIMIT_BIT) ? k - EDGE_LIMIT_BIT : 0;
		for (int i = 0; i < 3; i++) begin
			e[i] = (e[i] < 0) ? -longint'(em[i] >> k) : longint'(em[i] >> k);
			f[i] = (f[i] < 0) ? -longint'(em[i+3] >> k) : longint'(em[i+3] >> k);
		end

		n[0] = e[1] * f[2] - e[2] * f[1];
		n[1] = e[2] * f[0] - e[0] * f[2];
		n[2] = e[0] * f[1] - e[1] * f[0];

		peak = 0;
		for (int i = 0; i < 3; i++) begin
			nm[i] = magnitude(n[i]);
			if (nm[i] > peak) peak = nm[i];
		end

		if (peak == 0) begin
			r.nx         = '0;
			r.ny         = '0;
			r.nz         = '0;
			r.degenerate = 1'b1;
			return r;
		end

		k = bit_length(peak);
		k = (k > NRM_MAG_BITS) ? k - NRM_MAG_BITS : 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			nm[i] = nm[i] >> k;
			sum   = sum + nm[i] * nm[i];
		end
		len = floor_sqrt(sum);

		// round half up on the magnitude, then apply the sign
		for (int i = 0; i < 3; i++) begin
			q       = ((nm[i] << (NORMAL_FRAC_BITS + 1)) / len + 1) >> 1;
			comp[i] = NB'((n[i] < 0) ? (~q + 1) : q);
		end
		r.nx         = comp[0];
		r.ny         = comp[1];
		r.nz         = comp[2];
		r.degenerate = 1'b0;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint exp_v);
		$display("[%0t] normal mismatch on %s: got %0d, expected %0d", $realtime, what, got,
			exp_v);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				corner_a[i] = 0;
				corner_b[i] = 0;
			end
			corner_phase = CORNER_A;
			normals_due.delete();
			mismatches   = 0;
			faces_due    = 0;
		end else begin
			// check the taken normal word first: it can never be the face of
			// a vertex taken at this same edge
			if (normal.valid && normal.ready) begin
				if (normals_due.size() == 0) begin
					report_mismatch("word with no face due (normal_x)",
						longint'(normal.normal_x), 0);
				end else begin
					want = normals_due.pop_front();
					if (normal.normal_x !== want.nx)
						report_mismatch("normal_x", longint'(normal.normal_x),
							longint'(want.nx));
					if (normal.normal_y !== want.ny)
						report_mismatch("normal_y", longint'(normal.normal_y),
							longint'(want.ny));
					if (normal.normal_z !== want.nz)
						report_mismatch("normal_z", longint'(normal.normal_z),
							longint'(want.nz));
					if (normal.degenerate !== want.degenerate)
						report_mismatch("degenerate", longint'(normal.degenerate),
							longint'(want.degenerate));
				end
			end

			if (vertex.valid && vertex.ready) begin
				corner_c[0] = longint'(vertex.x_coord);
				corner_c[1] = longint'(vertex.y_coord);
				corner_c[2] = longint'(vertex.z_coord);
				phase_now   = vertex.start_of_mesh ? CORNER_A : corner_phase;
				case (phase_now)
					CORNER_A: begin
						corner_a     = corner_c;
						corner_phase = CORNER_B;
					end
					CORNER_B: begin
						corner_b     = corner_c;
						corner_phase = 2'd2;
					end
					default: begin
						normals_due.push_back(face_normal(corner_a, corner_b, corner_c));
						corner_phase = CORNER_A;
					end
				endcase
			end
			faces_due = normals_due.size();
		end
	end

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb: triangle face normal testbench
// Feeds vertex words to the block: a directed set of corner cases, then random
// meshes with broken groups and restarts mixed in, with random idling on both
// channels. A scoreboard beside the block predicts and checks every normal.
// ----------------------------------------------------------------------------
module tb
	import tfn_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB  = COORD_BITS_DEF;
	localparam int NFB = NORMAL_FRAC_BITS_DEF;

	// how many vertex words the random part sends at the least
	localparam int RANDOM_WORDS = 400;

	localparam logic signed [CB-1:0] COORD_MAX = {1'b0, {(CB-1){1'b1}}};
	localparam logic signed [CB-1:0] COORD_MIN = {1'b1, {(CB-1){1'b0}}};

	typedef enum int {
		STYLE_FULL,     // any bit pattern
		STYLE_SMALL,    // within 64 units of the origin
		STYLE_EXTREME   // the rails, their neighbors, -1 and 0
	} coord_style_t;

	typedef struct packed {
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
		logic signed [CB-1:0] z;
	} point_t;

	logic clk = 1'b0;
	logic arst_n;
	int   mismatches;
	int   faces_due;
	int   words_sent;
	bit   calm;         // when set, neither side idles

	tfn_vtx_if #(.COORD_BITS(CB))        vertex_ch ();
	tfn_nrm_if #(.NORMAL_FRAC_BITS(NFB)) normal_ch ();

	triangle_face_normal #(
		.COORD_BITS       (CB),
		.NORMAL_FRAC_BITS (NFB)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.vertex (vertex_ch),
		.normal (normal_ch)
	);

	tfn_face_checker #(
		.COORD_BITS       (CB),
		.NORMAL_FRAC_BITS (NFB)
	) face_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.vertex     (vertex_ch),
		.normal     (normal_ch),
		.mismatches (mismatches),
		.faces_due  (faces_due)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Idle length in cycles: mostly none or short, now and then long.
	function automatic int idle_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic point_t point(input int x, input int y, input int z);
		point_t p;
		p.x = CB'(x);
		p.y = CB'(y);
		p.z = CB'(z);
		return p;
	endfunction

	function automatic logic signed [CB-1:0] pick_coord(input coord_style_t style);
		case (style)
			STYLE_SMALL:   return CB'(int'($urandom_range(0, 128)) - 64);
			STYLE_EXTREME: begin
				case ($urandom_range(0, 5))
					0:       return COORD_MIN;
					1:       return COORD_MAX;
					2:       return COORD_MIN + CB'(1);
					3:       return COORD_MAX - CB'(1);
					4:       return '1;
					default: return '0;
				endcase
			end
			default:       return CB'($urandom);
		endcase
	endfunction

	function automatic point_t pick_point(input coord_style_t style);
		point_t p;
		p.x = pick_coord(style);
		p.y = pick_coord(style);
		p.z = pick_coord(style);
		return p;
	endfunction

	// Present one vertex word and hold it until the block takes it. Drop
	// valid only for an idle stretch, so it is never lowered and raised in
	// the same step.
	task automatic send_vertex(input point_t p, input bit restart);
		int gap;
		gap = idle_len();
		@(negedge clk);
		if (gap > 0) begin
			vertex_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		vertex_ch.x_coord       <= p.x;
		vertex_ch.y_coord       <= p.y;
		vertex_ch.z_coord       <= p.z;
		vertex_ch.start_of_mesh <= restart;
		vertex_ch.valid         <= 1'b1;
		do @(posedge clk); while (!vertex_ch.ready);
		words_sent++;
	endtask

	// Stop sending until every predicted normal has come back.
	task automatic hold_until_drained();
		@(negedge clk);
		vertex_ch.valid <= 1'b0;
		while (faces_due != 0) @(negedge clk);
	endtask

	// Normal channel receiver: stall at random, mostly while a word is
	// waiting so that the back pressure reaches the block's last stage.
	initial begin
		int   stall_left;
		logic next_ready;
		stall_left      = 0;
		normal_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (calm) begin
				next_ready = 1'b1;
				stall_left = 0;
			end else if (stall_left > 0) begin
				next_ready = 1'b0;
				stall_left--;
			end else if (normal_ch.valid && $urandom_range(0, 1) == 0) begin
				stall_left = idle_len();
				next_ready = (stall_left == 0);
				if (stall_left > 0) stall_left--;
			end else begin
				next_ready = ($urandom_range(0, 7) != 0);
			end
			normal_ch.ready <= next_ready;
		end
	end

	// Hard limit on the whole run.
	initial begin
		#3ms;
		$display("Verification failed");
		$finish;
	end

	initial begin
		point_t       a;
		point_t       b;
		point_t       c;
		point_t       d;
		coord_style_t style;
		bit           force_start;
		int           roll;
		int           next_pause;
		int           drain_cycles;

		arst_n                  <= 1'b0;
		vertex_ch.valid         <= 1'b0;
		vertex_ch.x_coord       <= '0;
		vertex_ch.y_coord       <= '0;
		vertex_ch.z_coord       <= '0;
		vertex_ch.start_of_mesh <= 1'b0;
		words_sent              = 0;
		calm                    = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// ---- directed part ----
		// right-handed triangle in the xy plane with legs of 256: normal straight up z
		send_vertex(point(0, 0, 0), 1'b1);
		send_vertex(point(256, 0, 0), 1'b0);
		send_vertex(point(0, 256, 0), 1'b0);
		// all three corners on one point: degenerate
		send_vertex(point(100, 100, 100), 1'b0);
		send_vertex(point(100, 100, 100), 1'b0);
		send_vertex(point(100, 100, 100), 1'b0);
		// collinear corners: degenerate with nonzero edges
		send_vertex(point(-3, -3, -3), 1'b0);
		send_vertex(point(1, 1, 1), 1'b0);
		send_vertex(point(5, 5, 5), 1'b0);
		// full-scale edges from the negative rail: widest cross product
		send_vertex(point(-32768, -32768, -32768), 1'b0);
		send_vertex(point(32767, -32768, -32768), 1'b0);
		send_vertex(point(-32768, 32767, 32767), 1'b0);
		// same from the positive rail: all nonzero edge components negative
		send_vertex(point(32767, 32767, 32767), 1'b0);
		send_vertex(point(-32768, 32767, -32768), 1'b0);
		send_vertex(point(32767, -32768, 32767), 1'b0);
		// restart in the middle of a group: the lone corner is dropped
		send_vertex(point(7, -9, 11), 1'b0);
		send_vertex(point(-1, 2, -3), 1'b1);
		send_vertex(point(40, 2, -3), 1'b0);
		send_vertex(point(-1, 2, 60), 1'b0);
		// two leftover corners, then a fresh mesh with a slanted face
		send_vertex(point(12, 34, 56), 1'b0);
		send_vertex(point(-78, 90, -12), 1'b0);
		send_vertex(point(1000, -2000, 300), 1'b1);
		send_vertex(point(-1500, 700, 2500), 1'b0);
		send_vertex(point(333, 4444, -5555), 1'b0);

		// let everything come back before the random part
		hold_until_drained();

		// ---- random part ----
		force_start = 1'b1;
		next_pause  = words_sent + $urandom_range(80, 160);
		while (words_sent < RANDOM_WORDS + 24) begin
			roll = $urandom_range(0, 99);
			calm = (words_sent >= 200 && words_sent < 260);
			if (roll < 12) begin
				// broken group: one or two stray corners, now and then with a restart
				repeat ($urandom_range(1, 2))
					send_vertex(pick_point(coord_style_t'($urandom_range(0, 2))),
						($urandom_range(0, 7) == 0));
				force_start = 1'($urandom_range(0, 1));
			end else begin
				style = coord_style_t'($urandom_range(0, 2));
				a = pick_point(style);
				b = pick_point(style);
				c = pick_point(style);
				if (roll < 18) begin
					// repeat a corner: degenerate
					c = ($urandom_range(0, 1) == 0) ? a : b;
				end else if (roll < 24) begin
					// collinear corners around the origin: degenerate
					a   = pick_point(STYLE_SMALL);
					d.x = CB'(int'($urandom_range(0, 64)) - 32);
					d.y = CB'(int'($urandom_range(0, 64)) - 32);
					d.z = CB'(int'($urandom_range(0, 64)) - 32);
					b   = point(int'(a.x) + int'(d.x), int'(a.y) + int'(d.y),
						int'(a.z) + int'(d.z));
					c   = point(int'(a.x) - 2 * int'(d.x), int'(a.y) - 2 * int'(d.y),
						int'(a.z) - 2 * int'(d.z));
				end
				send_vertex(a, force_start | ($urandom_range(0, 3) == 0));
				send_vertex(b, 1'b0);
				send_vertex(c, 1'b0);
				force_start = 1'b0;
			end
			if (words_sent >= next_pause) begin
				hold_until_drained();
				next_pause = words_sent + $urandom_range(80, 160);
			end
		end
		calm = 1'b0;

		// close the stream and wait for the last faces
		@(negedge clk);
		vertex_ch.valid <= 1'b0;
		drain_cycles = 0;
		while (faces_due != 0 && drain_cycles < 20000) begin
			@(negedge clk);
			drain_cycles++;
		end
		repeat (200) @(negedge clk);

		if (mismatches == 0 && faces_due == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
